// ===== rtl/pidc_pkg.sv =====
// ----------------------------------------------------------------------------
// pidc_pkg
// Shared types, constants and saturation helpers for the clamped PID block.
// ----------------------------------------------------------------------------
`default_nettype none

package pidc_pkg;

  localparam int WordW  = 32;
  localparam int ProdW  = 64;
  localparam int AccW   = 50;
  localparam int FracW  = 16;
  localparam int RegIdxW = 3;

  localparam logic signed [WordW-1:0] DT_Q16 = 32'sd655;
  localparam logic signed [WordW-1:0] INV_DT = 32'sd100;

  localparam logic signed [WordW-1:0] WORD_MIN = {1'b1, {(WordW-1){1'b0}}};
  localparam logic signed [WordW-1:0] WORD_MAX = {1'b0, {(WordW-1){1'b1}}};

  localparam logic [RegIdxW-1:0] REG_GAIN_P        = 3'd0;
  localparam logic [RegIdxW-1:0] REG_GAIN_I        = 3'd1;
  localparam logic [RegIdxW-1:0] REG_GAIN_D        = 3'd2;
  localparam logic [RegIdxW-1:0] REG_DRIVE_FLOOR   = 3'd3;
  localparam logic [RegIdxW-1:0] REG_DRIVE_CEILING = 3'd4;
  localparam logic [RegIdxW-1:0] REG_ACCUM_FLOOR   = 3'd5;
  localparam logic [RegIdxW-1:0] REG_ACCUM_CEILING = 3'd6;

  localparam logic [2:0] STEP_NONE = 3'd0;
  localparam logic [2:0] STEP_DT   = 3'd1;
  localparam logic [2:0] STEP_DIFF = 3'd2;
  localparam logic [2:0] STEP_P    = 3'd3;
  localparam logic [2:0] STEP_I    = 3'd4;
  localparam logic [2:0] STEP_D    = 3'd5;
  localparam logic [2:0] STEP_SUM  = 3'd6;

  typedef logic signed [WordW-1:0] word_t;

  typedef struct packed {
    logic       load;
    logic [2:0] step;
    logic       finish;
  } pidc_cmd_t;

  function automatic word_t sat32(input logic signed [ProdW-1:0] x);
    if (x > ProdW'(WORD_MAX)) begin
      return WORD_MAX;
    end else if (x < ProdW'(WORD_MIN)) begin
      return WORD_MIN;
    end
    return word_t'(x[WordW-1:0]);
  endfunction

  function automatic word_t clamp32(input word_t x, input word_t lo, input word_t hi);
    if (x < lo) begin
      return lo;
    end else if (x > hi) begin
      return hi;
    end
    return x;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/pidc_if.sv =====
// ----------------------------------------------------------------------------
// pidc channel interfaces
// Valid/ready channels for the sample input and the drive result.
// ----------------------------------------------------------------------------
`default_nettype none

interface pidc_in_if import pidc_pkg::*; ();
  logic  valid;
  logic  ready;
  word_t target;
  word_t measured;

  modport source (output valid, output target, output measured, input ready);
  modport sink   (input valid, input target, input measured, output ready);
endinterface

interface pidc_out_if import pidc_pkg::*; ();
  logic  valid;
  logic  ready;
  word_t drive;

  modport source (output valid, output drive, input ready);
  modport sink   (input valid, input drive, output ready);
endinterface

`default_nettype wire

// ===== rtl/pidc_ctrl.sv =====
// ----------------------------------------------------------------------------
// pidc_ctrl
// Sequencer for the PID step: accepts a sample, walks the shared multiplier
// through its five products and the final sum, and owns the output valid.
// ----------------------------------------------------------------------------
`default_nettype none

module pidc_ctrl import pidc_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  output pidc_cmd_t cmd
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DT   = 3'd1;
  localparam logic [2:0] S_DIFF = 3'd2;
  localparam logic [2:0] S_P    = 3'd3;
  localparam logic [2:0] S_I    = 3'd4;
  localparam logic [2:0] S_D    = 3'd5;
  localparam logic [2:0] S_SUM  = 3'd6;
  localparam logic [2:0] S_OUT  = 3'd7;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       slot_free;

  assign in_ready  = (state == S_IDLE);
  assign slot_free = !out_valid || out_ready;

  always_comb begin
    state_next = state;
    cmd.load   = 1'b0;
    cmd.finish = 1'b0;
    cmd.step   = STEP_NONE;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_DT;
        end
      end
      S_DT: begin
        cmd.step   = STEP_DT;
        state_next = S_DIFF;
      end
      S_DIFF: begin
        cmd.step   = STEP_DIFF;
        state_next = S_P;
      end
      S_P: begin
        cmd.step   = STEP_P;
        state_next = S_I;
      end
      S_I: begin
        cmd.step   = STEP_I;
        state_next = S_D;
      end
      S_D: begin
        cmd.step   = STEP_D;
        state_next = S_SUM;
      end
      S_SUM: begin
        cmd.step   = STEP_SUM;
        state_next = S_OUT;
      end
      S_OUT: begin
        if (slot_free) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.finish) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/pidc_dp.sv =====
// ----------------------------------------------------------------------------
// pidc_dp
// PID datapath: configuration registers, loop state, one shared 32x32
// multiplier with a registered product, term accumulator and output clamp.
// ----------------------------------------------------------------------------
`default_nettype none

module pidc_dp import pidc_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               write_enable,
  input  logic [RegIdxW-1:0] reg_index,
  input  word_t              write_data,
  input  pidc_cmd_t          cmd,
  input  word_t              target,
  input  word_t              measured,
  output word_t              drive
);

  word_t gain_p;
  word_t gain_i;
  word_t gain_d;
  word_t drive_floor;
  word_t drive_ceiling;
  word_t accum_floor;
  word_t accum_ceiling;

  word_t integral_sum;
  word_t previous_error;
  word_t err;
  word_t delta;

  logic signed [ProdW-1:0] prod;
  logic signed [ProdW-1:0] prod_q;
  logic signed [ProdW-1:0] mul_out;
  logic signed [AccW-1:0]  acc;
  word_t                   mul_a;
  word_t                   mul_b;
  logic signed [WordW:0]   in_diff;
  logic signed [WordW:0]   err_diff;

  assign in_diff  = (WordW+1)'(target) - (WordW+1)'(measured);
  assign err_diff = (WordW+1)'(err) - (WordW+1)'(previous_error);
  assign mul_out  = ProdW'(mul_a) * ProdW'(mul_b);
  assign prod_q   = prod >>> FracW;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.step)
      STEP_DT: begin
        mul_a = err;
        mul_b = DT_Q16;
      end
      STEP_DIFF: begin
        mul_a = delta;
        mul_b = INV_DT;
      end
      STEP_P: begin
        mul_a = gain_p;
        mul_b = err;
      end
      STEP_I: begin
        mul_a = gain_i;
        mul_b = integral_sum;
      end
      STEP_D: begin
        mul_a = gain_d;
        mul_b = delta;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      gain_p        <= '0;
      gain_i        <= '0;
      gain_d        <= '0;
      drive_floor   <= WORD_MIN;
      drive_ceiling <= WORD_MAX;
      accum_floor   <= WORD_MIN;
      accum_ceiling <= WORD_MAX;
    end else if (write_enable) begin
      unique case (reg_index)
        REG_GAIN_P:        gain_p        <= write_data;
        REG_GAIN_I:        gain_i        <= write_data;
        REG_GAIN_D:        gain_d        <= write_data;
        REG_DRIVE_FLOOR:   drive_floor   <= write_data;
        REG_DRIVE_CEILING: drive_ceiling <= write_data;
        REG_ACCUM_FLOOR:   accum_floor   <= write_data;
        REG_ACCUM_CEILING: accum_ceiling <= write_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      integral_sum   <= '0;
      previous_error <= '0;
    end else begin
      if (cmd.step == STEP_DIFF) begin
        integral_sum <= clamp32(sat32(ProdW'(integral_sum) + prod_q),
                                accum_floor, accum_ceiling);
      end
      if (cmd.finish) begin
        previous_error <= err;
      end
    end
  end

  always_ff @(posedge clk) begin
    prod <= mul_out;
    if (cmd.load) begin
      err <= sat32(ProdW'(in_diff));
    end
    case (cmd.step)
      STEP_DT:  delta <= sat32(ProdW'(err_diff));
      STEP_P:   delta <= sat32(prod);
      STEP_I:   acc   <= AccW'(prod_q);
      STEP_D:   acc   <= acc + AccW'(prod_q);
      STEP_SUM: acc   <= acc + AccW'(prod_q);
      default: ;
    endcase
    if (cmd.finish) begin
      drive <= clamp32(sat32(ProdW'(acc)), drive_floor, drive_ceiling);
    end
  end

endmodule

`default_nettype wire

// ===== rtl/pid_controller_clamped.sv =====
// ----------------------------------------------------------------------------
// pid_controller_clamped
// Positional PID controller in signed Q16.16 with integral and output clamps.
// ----------------------------------------------------------------------------
// Each accepted sample (target, measured) produces one drive value. After its
// transfer on the sample side, the sequencer registers the error, then runs
// five products through a single shared 32x32 multiplier (error*dt,
// delta*100, and the three gain terms) plus a final accumulate and clamp
// before the next transfer. The drive sits in an output register, so the
// next sample is taken while a result waits; only a second result blocked
// behind an untaken one holds the sequencer. Configure through write_enable,
// reg_index and write_data while idle; unknown indexes are ignored.
// ----------------------------------------------------------------------------
`default_nettype none

module pid_controller_clamped import pidc_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               write_enable,
  input  logic [RegIdxW-1:0] reg_index,
  input  word_t              write_data,
  pidc_in_if.sink            sample,
  pidc_out_if.source         result
);

  pidc_cmd_t cmd;

  pidc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (sample.valid),
    .in_ready  (sample.ready),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .cmd       (cmd)
  );

  pidc_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .write_enable (write_enable),
    .reg_index    (reg_index),
    .write_data   (write_data),
    .cmd          (cmd),
    .target       (sample.target),
    .measured     (sample.measured),
    .drive        (result.drive)
  );

  a_busy_after_transfer: assert property (@(posedge clk) disable iff (rst)
    sample.valid && sample.ready |=> !sample.ready)
    else $error("sample accepted while a step is in flight");

  a_result_from_step: assert property (@(posedge clk) disable iff (rst)
    $rose(result.valid) |-> $past(!sample.ready))
    else $error("result raised without a step in flight");

  a_load_only_when_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.load |-> sample.ready && cmd.step == STEP_NONE && !cmd.finish)
    else $error("load issued outside idle");

endmodule

`default_nettype wire
